// ===== sv/swf_pkg.sv =====
// shared constants, types and the quarter-wave sine function of the wow/flutter delay
`default_nettype none

package swf_pkg;

	localparam int LINE_DEPTH   = 32768;
	localparam int SINE_ENTRIES = 1024;

	localparam int AW       = $clog2(LINE_DEPTH);
	localparam int SAMPLE_W = 24;
	localparam int FRAC_W   = 8;
	localparam int DELAY_W  = AW + FRAC_W;
	localparam int BASE_W   = 23;
	localparam int DEPTH_W  = 21;
	localparam int MOD_W    = 25;
	localparam int PHASE_W  = 32;
	localparam int MPROD_W  = MOD_W + DEPTH_W;
	localparam int OFF_W    = MPROD_W - 23;
	localparam int SUM_W    = (DELAY_W + 1 > 25) ? DELAY_W + 1 : 25;
	localparam int IPROD_W  = SAMPLE_W + 1 + FRAC_W + 1;
	localparam int SIDX_W   = $clog2(SINE_ENTRIES);
	localparam int QUARTER  = SINE_ENTRIES / 4;
	localparam int QIDX_W   = SIDX_W - 1;

	// configuration register indexes
	localparam int REG_W = 3;
	localparam logic [REG_W-1:0] REG_TRANSPORT   = 3'd0;
	localparam logic [REG_W-1:0] REG_WOW_STEP    = 3'd1;
	localparam logic [REG_W-1:0] REG_FLUT_STEP   = 3'd2;
	localparam logic [REG_W-1:0] REG_LEFT_BASE   = 3'd3;
	localparam logic [REG_W-1:0] REG_RIGHT_BASE  = 3'd4;
	localparam logic [REG_W-1:0] REG_LEFT_DEPTH  = 3'd5;
	localparam logic [REG_W-1:0] REG_RIGHT_DEPTH = 3'd6;

	localparam logic [PHASE_W-1:0]        RST_WOW_STEP    = 32'd49213;
	localparam logic [PHASE_W-1:0]        RST_FLUT_STEP   = 32'd187905;
	localparam logic [BASE_W-1:0]         RST_LEFT_BASE   = 23'd98304;
	localparam logic [BASE_W-1:0]         RST_RIGHT_BASE  = 23'd114278;
	localparam logic signed [DEPTH_W-1:0] RST_LEFT_DEPTH  = 21'sd1229;
	localparam logic signed [DEPTH_W-1:0] RST_RIGHT_DEPTH = -21'sd885;

	typedef struct packed {
		logic          en;
		logic [AW-1:0] addr;
	} line_wr_t;

	// quarter-wave sine entry j (0..QUARTER) in Q1.23, clamped to [0, 1]
	function automatic logic [SAMPLE_W-1:0] qsine_val(input int j);
		longint t;
		longint t2;
		longint p;
		t  = longint'(j) <<< (30 - (SIDX_W - 2));
		t2 = (t * t) >>> 30;
		p  = 64'sd3864;
		p  = 64'sd172272 - ((p * t2) >>> 30);
		p  = 64'sd5026995 - ((p * t2) >>> 30);
		p  = 64'sd85569306 - ((p * t2) >>> 30);
		p  = 64'sd693598668 - ((p * t2) >>> 30);
		p  = 64'sd1686629713 - ((p * t2) >>> 30);
		p  = (p * t) >>> 30;
		if (p < 0) begin
			p = 0;
		end
		if (p > 64'sd1073741824) begin
			p = 64'sd1073741824;
		end
		p = (p + 64) >>> 7;
		return p[SAMPLE_W-1:0];
	endfunction

endpackage

`default_nettype wire

// ===== sv/stereo_wow_flutter_delay.sv =====
// a frame runs through the per-channel chain of modulator, delay multiply, delay saturate,
//   line read, interpolate multiply and output register; a new input beat is taken only once
//   the last result is loaded, and that load waits while the master side holds the previous beat
// reset: both delay lines are swept to zero, one address a cycle over all 32768 addresses,
//   with s_axis_tready low; registers return to their defaults, phases and index to zero
`default_nettype none

module stereo_wow_flutter_delay
	import swf_pkg::*;
(
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      s_axis_tvalid,
	output logic                           s_axis_tready,
	input  wire logic [2*SAMPLE_W-1:0]     s_axis_tdata,  // left_in, right_in
	output logic                           m_axis_tvalid,
	input  wire logic                      m_axis_tready,
	output logic [2*SAMPLE_W-1:0]          m_axis_tdata,  // left_out, right_out
	input  wire logic                      cfg_valid,
	output logic                           cfg_ready,
	input  wire logic [REG_W-1:0]          cfg_index,
	input  wire logic [31:0]               cfg_data
);

	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_IDLE  = 2'd1;
	localparam logic [1:0] ST_RUN   = 2'd2;

	localparam logic [2:0] LAST_STEP = 3'd5;

	logic [1:0]                   state_q;
	logic [2:0]                   step_q;
	logic [AW-1:0]                clr_q;
	logic [AW-1:0]                wi_q;
	logic                         out_valid_q;
	logic [2*SAMPLE_W-1:0]        out_data_q;
	logic [2*SAMPLE_W-1:0]        smp_q;
	logic                         en_q;

	logic                         transport_q;
	logic [PHASE_W-1:0]           wow_step_q;
	logic [PHASE_W-1:0]           flut_step_q;
	logic [BASE_W-1:0]            left_base_q;
	logic [BASE_W-1:0]            right_base_q;
	logic signed [DEPTH_W-1:0]    left_amt_q;
	logic signed [DEPTH_W-1:0]    right_amt_q;

	logic                         s_accept;
	logic                         out_free;
	logic                         finish;
	logic                         clearing;
	line_wr_t                     wr;
	logic [SAMPLE_W-1:0]          left_wr_data;
	logic [SAMPLE_W-1:0]          right_wr_data;
	logic signed [MOD_W-1:0]      sine;
	logic signed [MOD_W-1:0]      tri_wave;
	logic [SAMPLE_W-1:0]          left_res;
	logic [SAMPLE_W-1:0]          right_res;

	assign clearing      = (state_q == ST_CLEAR);
	assign s_axis_tready = (state_q == ST_IDLE);
	assign s_accept      = s_axis_tvalid && s_axis_tready;
	assign out_free      = !out_valid_q || m_axis_tready;
	assign finish        = (state_q == ST_RUN) && (step_q == LAST_STEP) && out_free;
	assign cfg_ready     = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			transport_q   <= 1'b1;
			wow_step_q    <= RST_WOW_STEP;
			flut_step_q   <= RST_FLUT_STEP;
			left_base_q   <= RST_LEFT_BASE;
			right_base_q  <= RST_RIGHT_BASE;
			left_amt_q    <= RST_LEFT_DEPTH;
			right_amt_q   <= RST_RIGHT_DEPTH;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_TRANSPORT:   transport_q   <= cfg_data[0];
				REG_WOW_STEP:    wow_step_q    <= cfg_data;
				REG_FLUT_STEP:   flut_step_q   <= cfg_data;
				REG_LEFT_BASE:   left_base_q   <= cfg_data[BASE_W-1:0];
				REG_RIGHT_BASE:  right_base_q  <= cfg_data[BASE_W-1:0];
				REG_LEFT_DEPTH:  left_amt_q    <= cfg_data[DEPTH_W-1:0];
				REG_RIGHT_DEPTH: right_amt_q   <= cfg_data[DEPTH_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			step_q      <= '0;
			clr_q       <= '0;
			wi_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == '1) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (s_accept) begin
						state_q <= ST_RUN;
						step_q  <= '0;
					end
				end
				ST_RUN: begin
					if (step_q != LAST_STEP) begin
						step_q <= step_q + 1'b1;
					end else if (out_free) begin
						state_q     <= ST_IDLE;
						out_valid_q <= 1'b1;
						wi_q        <= wi_q + 1'b1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			smp_q <= s_axis_tdata;
			en_q  <= transport_q;
		end
		// merge the two lanes, or pass the frame through
		if (finish) begin
			if (en_q) begin
				out_data_q <= {right_res, left_res};
			end else begin
				out_data_q <= smp_q;
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	// line write: zero sweep after reset, else the accepted frame at the write index while transport is on
	assign wr = '{en: clearing || (s_accept && transport_q), addr: clearing ? clr_q : wi_q};
	assign left_wr_data  = clearing ? '0 : s_axis_tdata[SAMPLE_W-1:0];
	assign right_wr_data = clearing ? '0 : s_axis_tdata[2*SAMPLE_W-1:SAMPLE_W];

	swf_modgen u_modgen (
		.clk          (clk),
		.arst_n       (arst_n),
		.advance      (s_accept && transport_q),
		.wow_step     (wow_step_q),
		.flutter_step (flut_step_q),
		.sine         (sine),
		.tri_wave     (tri_wave)
	);

	swf_lane u_left (
		.clk         (clk),
		.wr          (wr),
		.wr_data     (left_wr_data),
		.write_index (wi_q),
		.modulation  (sine),
		.base_delay  (left_base_q),
		.mod_depth   (left_amt_q),
		.result      (left_res)
	);

	swf_lane u_right (
		.clk         (clk),
		.wr          (wr),
		.wr_data     (right_wr_data),
		.write_index (wi_q),
		.modulation  (tri_wave),
		.base_delay  (right_base_q),
		.mod_depth   (right_amt_q),
		.result      (right_res)
	);

	// the lines must not be written while a frame is being read out of them
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |-> !wr.en)
		else $error("line write during frame processing");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |-> (step_q <= LAST_STEP))
		else $error("step counter ran past the last step");

	assert property (@(posedge clk) disable iff (!arst_n)
		s_accept |=> (state_q == ST_RUN) && (step_q == '0) && $stable(wi_q))
		else $error("accepted frame did not start a run");

	assert property (@(posedge clk) disable iff (!arst_n)
		finish |=> m_axis_tvalid && (wi_q == $past(wi_q) + 1'b1))
		else $error("finished frame did not load the output or advance the index");

endmodule

`default_nettype wire

// ===== sv/swf_modgen.sv =====
// wow and flutter phase accumulators with sine and triangle modulators
`default_nettype none

module swf_modgen
	import swf_pkg::*;
(
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      advance,
	input  wire logic [PHASE_W-1:0]        wow_step,
	input  wire logic [PHASE_W-1:0]        flutter_step,
	output logic signed [MOD_W-1:0]        sine,
	output logic signed [MOD_W-1:0]        tri_wave
);

	localparam logic [PHASE_W-1:0] QTR_TURN  = 32'h4000_0000;
	localparam logic [PHASE_W-1:0] HALF_TURN = 32'h8000_0000;
	localparam logic [PHASE_W-1:0] TQ_TURN   = 32'hC000_0000;

	logic [PHASE_W-1:0]        wow_phase_q;
	logic [PHASE_W-1:0]        flutter_phase_q;
	logic [SAMPLE_W-1:0]       qsine_w [0:QUARTER];
	logic [SIDX_W-1:0]         sidx;
	logic [1:0]                quad;
	logic [QIDX_W-1:0]         qidx;
	logic [PHASE_W-1:0]        tri_diff;
	logic [MOD_W-1:0]          tri_mag;
	logic                      tri_neg;
	logic signed [MOD_W-1:0]   sine_s1;
	logic signed [MOD_W-1:0]   tri_s1;

	for (genvar j = 0; j <= QUARTER; j++) begin : g_qsine
		assign qsine_w[j] = qsine_val(j);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wow_phase_q     <= '0;
			flutter_phase_q <= '0;
		end else if (advance) begin
			wow_phase_q     <= wow_phase_q + wow_step;
			flutter_phase_q <= flutter_phase_q + flutter_step;
		end
	end

	assign sidx = wow_phase_q[PHASE_W-1 -: SIDX_W];
	assign quad = sidx[SIDX_W-1 -: 2];

	// odd quadrants mirror the quarter wave
	always_comb begin
		if (quad[0]) begin
			qidx = QIDX_W'(QUARTER) - {1'b0, sidx[SIDX_W-3:0]};
		end else begin
			qidx = {1'b0, sidx[SIDX_W-3:0]};
		end
	end

	always_comb begin
		if (flutter_phase_q < QTR_TURN) begin
			tri_diff = flutter_phase_q;
			tri_neg  = 1'b0;
		end else if (flutter_phase_q <= HALF_TURN) begin
			tri_diff = HALF_TURN - flutter_phase_q;
			tri_neg  = 1'b0;
		end else if (flutter_phase_q < TQ_TURN) begin
			tri_diff = flutter_phase_q - HALF_TURN;
			tri_neg  = 1'b1;
		end else begin
			tri_diff = '0 - flutter_phase_q;
			tri_neg  = 1'b1;
		end
		tri_mag = tri_diff[PHASE_W-1:7];
	end

	always_ff @(posedge clk) begin
		if (quad[1]) begin
			sine_s1 <= -$signed({1'b0, qsine_w[qidx]});
		end else begin
			sine_s1 <= $signed({1'b0, qsine_w[qidx]});
		end
		if (tri_neg) begin
			tri_s1 <= -$signed(tri_mag);
		end else begin
			tri_s1 <= $signed(tri_mag);
		end
	end

	assign sine     = sine_s1;
	assign tri_wave = tri_s1;

endmodule

`default_nettype wire

// ===== sv/swf_lane.sv =====
// one channel: delay line memory, modulated delay and linear interpolation
`default_nettype none

module swf_lane
	import swf_pkg::*;
(
	input  wire logic                        clk,
	input  wire line_wr_t                    wr,
	input  wire logic [SAMPLE_W-1:0]         wr_data,
	input  wire logic [AW-1:0]               write_index,
	input  wire logic signed [MOD_W-1:0]     modulation,
	input  wire logic [BASE_W-1:0]           base_delay,
	input  wire logic signed [DEPTH_W-1:0]   mod_depth,
	output logic [SAMPLE_W-1:0]              result
);

	localparam logic signed [SUM_W-1:0]   DLY_HI = SUM_W'((LINE_DEPTH - 2) * 256);
	localparam logic signed [SUM_W-1:0]   DLY_LO = SUM_W'(256);
	localparam logic signed [MPROD_W-1:0] RND_D  = MPROD_W'(1 << 22);
	localparam logic signed [IPROD_W-1:0] RND_I  = IPROD_W'(128);

	logic [SAMPLE_W-1:0]              line_mem [LINE_DEPTH];

	logic signed [MPROD_W-1:0]        mprod_s2;
	logic signed [MPROD_W-1:0]        mrnd;
	logic signed [OFF_W-1:0]          offset;
	logic signed [SUM_W-1:0]          dsum;
	logic [DELAY_W-1:0]               delay_s3;
	logic [DELAY_W-1:0]               pos;
	logic [AW-1:0]                    first;
	logic [AW-1:0]                    second;
	logic signed [SAMPLE_W-1:0]       a_s4;
	logic signed [SAMPLE_W-1:0]       b_s4;
	logic [FRAC_W-1:0]                frac_s4;
	logic signed [SAMPLE_W:0]         diff;
	logic signed [IPROD_W-1:0]        iprod_s5;
	logic signed [SAMPLE_W-1:0]       a_s5;
	logic signed [IPROD_W-1:0]        irnd;
	logic signed [IPROD_W-FRAC_W-1:0] istep;
	logic signed [IPROD_W-FRAC_W-1:0] isum;

	// delay = base + round(mod * depth / 2^23), saturated to the line
	assign mrnd   = mprod_s2 + RND_D;
	assign offset = mrnd[MPROD_W-1:23];
	assign dsum   = SUM_W'({1'b0, base_delay}) + SUM_W'(offset);

	always_ff @(posedge clk) begin
		mprod_s2 <= modulation * mod_depth;
		if (dsum > DLY_HI) begin
			delay_s3 <= DLY_HI[DELAY_W-1:0];
		end else if (dsum < DLY_LO) begin
			delay_s3 <= DLY_LO[DELAY_W-1:0];
		end else begin
			delay_s3 <= dsum[DELAY_W-1:0];
		end
	end

	// read position wraps naturally in the power-of-two line
	assign pos    = {write_index, {FRAC_W{1'b0}}} - delay_s3;
	assign first  = pos[DELAY_W-1:FRAC_W];
	assign second = first + 1'b1;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			line_mem[wr.addr] <= wr_data;
		end
		a_s4 <= line_mem[first];
		b_s4 <= line_mem[second];
	end

	always_ff @(posedge clk) begin
		frac_s4  <= pos[FRAC_W-1:0];
		iprod_s5 <= diff * $signed({1'b0, frac_s4});
		a_s5     <= a_s4;
	end

	assign diff   = (SAMPLE_W + 1)'(b_s4) - (SAMPLE_W + 1)'(a_s4);
	assign irnd   = iprod_s5 + RND_I;
	assign istep  = irnd[IPROD_W-1:FRAC_W];
	assign isum   = (IPROD_W - FRAC_W)'(a_s5) + istep;
	assign result = isum[SAMPLE_W-1:0];

endmodule

`default_nettype wire

// ===== test/tb_stereo_wow_flutter_delay.sv =====
// self-checking testbench for the stereo wow/flutter delay with its own model of both delay lines
`default_nettype none

module tb_stereo_wow_flutter_delay;
	import swf_pkg::*;

	localparam int     HALF_PERIOD  = 10;
	localparam int     CYCLE_LIMIT  = 400000;
	localparam int     DRAIN_CYCLES = 24;
	localparam int     HOLD_CYCLES  = 600;
	localparam int     RANDOM_ITEMS = 1150;
	localparam logic [REG_W-1:0] REG_SPARE = 3'd7;
	localparam longint Q30_ONE      = 64'sd1073741824;
	localparam longint DELAY_MIN    = 256;
	localparam longint DELAY_MAX    = longint'(LINE_DEPTH - 2) * 256;
	localparam logic [31:0] BASE_LO = 32'd256;
	localparam logic [31:0] BASE_HI = 32'd8388096;
	localparam logic [SAMPLE_W-1:0] S_MAX  = 24'h7FFFFF;
	localparam logic [SAMPLE_W-1:0] S_MIN  = 24'h800000;
	localparam logic [SAMPLE_W-1:0] S_NEG1 = 24'hFFFFFF;

	logic                  clk           = 1'b0;
	logic                  arst_n        = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [2*SAMPLE_W-1:0] s_axis_tdata  = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [2*SAMPLE_W-1:0] m_axis_tdata;
	logic                  cfg_valid     = 1'b0;
	logic                  cfg_ready;
	logic [REG_W-1:0]      cfg_index     = '0;
	logic [31:0]           cfg_data      = '0;

	stereo_wow_flutter_delay uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #HALF_PERIOD clk = ~clk;

	// model state
	logic signed [SAMPLE_W-1:0] left_tape  [LINE_DEPTH];
	logic signed [SAMPLE_W-1:0] right_tape [LINE_DEPTH];
	int                         sine_q23   [SINE_ENTRIES];
	logic [AW-1:0]              head_idx;
	logic [PHASE_W-1:0]         wow_acc;
	logic [PHASE_W-1:0]         flut_acc;
	logic                       tape_on;
	logic [PHASE_W-1:0]         wow_inc;
	logic [PHASE_W-1:0]         flut_inc;
	logic [BASE_W-1:0]          left_base;
	logic [BASE_W-1:0]          right_base;
	logic signed [DEPTH_W-1:0]  left_amt;
	logic signed [DEPTH_W-1:0]  right_amt;

	logic [2*SAMPLE_W-1:0] pending_frame_q [$];
	logic [2*SAMPLE_W-1:0] delayed_frame_q [$];
	int frames_queued  = 0;
	int frames_taken   = 0;
	int results_seen   = 0;
	int mismatch_count = 0;
	int cycle_count    = 0;

	// pacing knobs, changed between phases
	int burst_max  = 8;
	int gap_max    = 4;
	int burst_left = 1;
	int gap_left   = 0;
	int rx_period  = 3;
	int rx_open    = 2;
	int rx_tick    = 0;
	int hold_left  = 0;
	logic hold_arm  = 1'b0;
	logic hold_used = 1'b0;

	function automatic longint tape_delay(longint base, longint modv, longint depth);
		longint d;
		d = base + ((modv * depth + 64'sd4194304) >>> 23);
		if (d > DELAY_MAX) d = DELAY_MAX;
		if (d < DELAY_MIN) d = DELAY_MIN;
		return d;
	endfunction

	function automatic longint flutter_tri(logic [PHASE_W-1:0] p);
		logic [PHASE_W-1:0] m;
		logic neg;
		neg = p > 32'h8000_0000;
		if (p < 32'h4000_0000) m = p;
		else if (p <= 32'h8000_0000) m = 32'h8000_0000 - p;
		else if (p < 32'hC000_0000) m = p - 32'h8000_0000;
		else m = 32'd0 - p;
		m = m >> 7;
		return neg ? -longint'({1'b0, m}) : longint'({1'b0, m});
	endfunction

	function automatic logic [SAMPLE_W-1:0] tape_read(bit right_ch, longint d);
		longint pos;
		longint a;
		longint b;
		longint fr;
		int first;
		int second;
		pos = longint'({1'b0, head_idx}) * 256 - d;
		if (pos < 0) pos += longint'(LINE_DEPTH) * 256;
		first  = int'(pos >>> 8);
		second = (first + 1) % LINE_DEPTH;
		fr     = pos & 255;
		if (right_ch) begin
			a = longint'(right_tape[first]);
			b = longint'(right_tape[second]);
		end else begin
			a = longint'(left_tape[first]);
			b = longint'(left_tape[second]);
		end
		return SAMPLE_W'(a + (((b - a) * fr + 128) >>> 8));
	endfunction

	// one accepted frame through the model; pushes the frame it must produce
	task automatic advance_tape(input logic [2*SAMPLE_W-1:0] frame);
		logic signed [SAMPLE_W-1:0] l_in;
		logic signed [SAMPLE_W-1:0] r_in;
		logic [SAMPLE_W-1:0] l_out;
		logic [SAMPLE_W-1:0] r_out;
		longint wow_mod;
		l_in  = frame[SAMPLE_W-1:0];
		r_in  = frame[2*SAMPLE_W-1:SAMPLE_W];
		l_out = l_in;
		r_out = r_in;
		if (tape_on) begin
			left_tape[head_idx]  = l_in;
			right_tape[head_idx] = r_in;
			wow_acc  += wow_inc;
			flut_acc += flut_inc;
			wow_mod = longint'(sine_q23[wow_acc[PHASE_W-1 -: SIDX_W]]);
			l_out = tape_read(1'b0, tape_delay(longint'(left_base), wow_mod,
				longint'(left_amt)));
			r_out = tape_read(1'b1, tape_delay(longint'(right_base), flutter_tri(flut_acc),
				longint'(right_amt)));
		end
		head_idx++;
		delayed_frame_q.push_back({r_out, l_out});
	endtask

	task automatic report_mismatch(input string what);
		mismatch_count++;
		$display("mismatch at result %0d: %s", results_seen, what);
	endtask

	// called right after a rising edge
	task automatic write_reg(input logic [REG_W-1:0] idx, input logic [31:0] val);
		@(posedge clk);
		cfg_index <= idx;
		cfg_data  <= val;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			REG_TRANSPORT:   tape_on     = val[0];
			REG_WOW_STEP:    wow_inc     = val;
			REG_FLUT_STEP:   flut_inc    = val;
			REG_LEFT_BASE:   left_base   = val[BASE_W-1:0];
			REG_RIGHT_BASE:  right_base  = val[BASE_W-1:0];
			REG_LEFT_DEPTH:  left_amt    = val[DEPTH_W-1:0];
			REG_RIGHT_DEPTH: right_amt   = val[DEPTH_W-1:0];
			default: ;
		endcase
		cfg_valid <= 1'b0;
	endtask

	task automatic queue_frame(input logic [SAMPLE_W-1:0] l, input logic [SAMPLE_W-1:0] r);
		pending_frame_q.push_back({r, l});
		frames_queued++;
	endtask

	task automatic wait_idle();
		@(posedge clk);
		while (frames_taken != frames_queued || delayed_frame_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic set_pacing(input int bmax, input int gmax, input int period, input int open);
		burst_max = bmax;
		gap_max   = gmax;
		rx_period = period;
		rx_open   = open;
	endtask

	function automatic logic [SAMPLE_W-1:0] pick_sample();
		case ($urandom_range(0, 19))
			0: return S_MAX;
			1: return S_MIN;
			2: return '0;
			3: return S_NEG1;
			default: return SAMPLE_W'($urandom);
		endcase
	endfunction

	function automatic logic [31:0] pick_step();
		case ($urandom_range(0, 7))
			0: return 32'd0;
			1: return 32'hFFFF_FFFF;
			2: return 32'h8000_0000;
			3, 4: return $urandom;
			default: return $urandom_range(0, 32'h0100_0000);
		endcase
	endfunction

	function automatic logic [31:0] pick_base();
		case ($urandom_range(0, 11))
			0: return BASE_LO;
			1: return BASE_HI;
			2: return $urandom_range(0, 255);
			3: return 32'h007F_FFFF;
			4: return $urandom;
			default: return $urandom_range(256, 96 * 256);
		endcase
	endfunction

	function automatic logic [31:0] pick_depth();
		logic [31:0] v;
		case ($urandom_range(0, 7))
			0: v = 32'h0010_0000;
			1: v = 32'h000F_FFFF;
			2: v = $urandom;
			default: v = $urandom_range(0, 8191) - 4096;
		endcase
		return v;
	endfunction

	// sender: bursts of random length, random gaps between them
	always @(posedge clk) begin : sender
		logic offer;
		offer = s_axis_tvalid;
		if (s_axis_tvalid && s_axis_tready) begin
			advance_tape(s_axis_tdata);
			frames_taken++;
			offer = 1'b0;
		end
		if (!offer && arst_n) begin
			if (gap_left > 0) begin
				gap_left--;
			end else if (pending_frame_q.size() > 0) begin
				s_axis_tdata <= pending_frame_q.pop_front();
				offer = 1'b1;
				if (burst_left > 1) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(1, burst_max);
					gap_left   = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
				end
			end
		end
		s_axis_tvalid <= offer;
	end

	// receiver: checks each result beat, stalls on a periodic pattern
	always @(posedge clk) begin : receiver
		logic [2*SAMPLE_W-1:0] want;
		if (m_axis_tvalid === 1'b1 && m_axis_tready) begin
			if (delayed_frame_q.size() == 0) begin
				report_mismatch($sformatf("unexpected beat %h", m_axis_tdata));
			end else begin
				want = delayed_frame_q.pop_front();
				if (m_axis_tdata[SAMPLE_W-1:0] !== want[SAMPLE_W-1:0])
					report_mismatch($sformatf("left_out %h, model %h",
						m_axis_tdata[SAMPLE_W-1:0], want[SAMPLE_W-1:0]));
				if (m_axis_tdata[2*SAMPLE_W-1:SAMPLE_W] !== want[2*SAMPLE_W-1:SAMPLE_W])
					report_mismatch($sformatf("right_out %h, model %h",
						m_axis_tdata[2*SAMPLE_W-1:SAMPLE_W], want[2*SAMPLE_W-1:SAMPLE_W]));
			end
			results_seen++;
		end
		rx_tick++;
		m_axis_tready <= (hold_left == 0) && ((rx_tick % rx_period) < rx_open);
	end

	// one long receiver hold-off so the block backs up into its input
	always @(posedge clk) begin : holdoff
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
		end else if (hold_arm && !hold_used) begin
			hold_left <= HOLD_CYCLES;
			hold_used <= 1'b1;
		end
	end

	always @(posedge clk) begin : watchdog
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin : stimulus
		int quad;
		int count;
		int random_sent;
		longint tq;
		longint t2;
		longint pq;

		// sine table in Q1.23 from the odd quarter-wave polynomial
		for (int k = 0; k < SINE_ENTRIES; k++) begin
			quad = (4 * k) / SINE_ENTRIES;
			tq   = (longint'((4 * k) % SINE_ENTRIES) <<< 30) / SINE_ENTRIES;
			if (quad % 2 == 1) tq = Q30_ONE - tq;
			t2 = (tq * tq) / Q30_ONE;
			pq = 3864;
			pq = 172272 - (pq * t2) / Q30_ONE;
			pq = 5026995 - (pq * t2) / Q30_ONE;
			pq = 85569306 - (pq * t2) / Q30_ONE;
			pq = 693598668 - (pq * t2) / Q30_ONE;
			pq = 1686629713 - (pq * t2) / Q30_ONE;
			pq = (pq * tq) / Q30_ONE;
			if (pq < 0) pq = 0;
			if (pq > Q30_ONE) pq = Q30_ONE;
			pq = (pq + 64) >>> 7;
			sine_q23[k] = (quad >= 2) ? -int'(pq) : int'(pq);
		end
		for (int k = 0; k < LINE_DEPTH; k++) begin
			left_tape[k]  = '0;
			right_tape[k] = '0;
		end
		head_idx    = '0;
		wow_acc     = '0;
		flut_acc    = '0;
		tape_on     = 1'b1;
		wow_inc     = RST_WOW_STEP;
		flut_inc    = RST_FLUT_STEP;
		left_base   = RST_LEFT_BASE;
		right_base  = RST_RIGHT_BASE;
		left_amt    = RST_LEFT_DEPTH;
		right_amt   = RST_RIGHT_DEPTH;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// register defaults, sample extremes
		set_pacing(4, 3, 3, 2);
		queue_frame(S_MAX, S_MIN);
		queue_frame(S_MIN, S_MAX);
		queue_frame('0, '0);
		queue_frame(S_NEG1, S_NEG1);
		queue_frame(24'h555555, 24'hAAAAAA);
		queue_frame(24'hAAAAAA, 24'h555555);
		wait_idle();

		// unassigned index is ignored; transport off passes samples through
		write_reg(REG_SPARE, 32'hFFFF_FFFF);
		write_reg(REG_TRANSPORT, 32'h0000_0000);
		queue_frame(S_MAX, S_MIN);
		queue_frame(S_MIN, S_MAX);
		queue_frame(S_NEG1, 24'h000001);
		queue_frame(24'h123456, S_NEG1);
		wait_idle();

		// shortest left delay, right delay below range; wow wraps every frame, flutter every other
		write_reg(REG_TRANSPORT, 32'h0000_0001);
		write_reg(REG_WOW_STEP, 32'hFFFF_FFFF);
		write_reg(REG_FLUT_STEP, 32'h8000_0000);
		write_reg(REG_LEFT_BASE, BASE_LO);
		write_reg(REG_RIGHT_BASE, 32'd0);
		write_reg(REG_LEFT_DEPTH, 32'd0);
		write_reg(REG_RIGHT_DEPTH, 32'h000F_FFFF);
		queue_frame(S_MAX, S_MAX);
		queue_frame(S_MIN, S_MIN);
		queue_frame(24'h400000, 24'hC00000);
		queue_frame(S_NEG1, 24'h000001);
		queue_frame('0, S_MAX);
		queue_frame(S_MAX, '0);
		wait_idle();

		// delays above range and most negative depth
		write_reg(REG_LEFT_BASE, BASE_HI);
		write_reg(REG_RIGHT_BASE, 32'hFFFF_FFFF);
		write_reg(REG_LEFT_DEPTH, 32'h0010_0000);
		write_reg(REG_RIGHT_DEPTH, 32'h0010_0000);
		queue_frame(S_MIN, S_MAX);
		queue_frame(S_MAX, S_MIN);
		queue_frame(24'h0F0F0F, 24'hF0F0F0);
		queue_frame(24'hF0F0F0, 24'h0F0F0F);
		wait_idle();

		// random phases; the first one runs back to back into a long stall
		random_sent = 0;
		while (random_sent < RANDOM_ITEMS) begin
			write_reg(REG_TRANSPORT, ($urandom_range(0, 6) == 0) ? 32'd0 : {$urandom} | 32'd1);
			write_reg(REG_WOW_STEP, pick_step());
			write_reg(REG_FLUT_STEP, pick_step());
			write_reg(REG_LEFT_BASE, pick_base());
			write_reg(REG_RIGHT_BASE, pick_base());
			write_reg(REG_LEFT_DEPTH, pick_depth());
			write_reg(REG_RIGHT_DEPTH, pick_depth());
			if ($urandom_range(0, 5) == 0)
				write_reg(REG_SPARE, $urandom);
			if (random_sent == 0) begin
				set_pacing(64, 0, 1, 1);
				count = 150;
			end else begin
				case ($urandom_range(0, 3))
					0: set_pacing(64, 0, 1, 1);
					default: begin
						rx_period = $urandom_range(1, 6);
						set_pacing($urandom_range(1, 12), $urandom_range(0, 12),
							rx_period, $urandom_range(1, rx_period));
					end
				endcase
				count = $urandom_range(30, 150);
			end
			for (int i = 0; i < count; i++)
				queue_frame(pick_sample(), pick_sample());
			if (random_sent == 0) begin
				@(posedge clk);
				hold_arm <= 1'b1;
			end
			random_sent += count;
			wait_idle();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && delayed_frame_q.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

`default_nettype wire

// ===== files.f =====
sv/swf_pkg.sv
sv/swf_modgen.sv
sv/swf_lane.sv
sv/stereo_wow_flutter_delay.sv
test/tb_stereo_wow_flutter_delay.sv
